FILE: design/kth_largest_stream_tracker_defines.svh
// ----------------------------------------------------------------------------
// kth largest stream tracker assertion macros
// shared concurrent assertion forms, clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef KTH_LARGEST_STREAM_TRACKER_DEFINES_SVH
`define KTH_LARGEST_STREAM_TRACKER_DEFINES_SVH

// condition implies a consequence in the same cycle
`define KLS_ASSERT_SAME(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// condition implies a consequence in the next cycle
`define KLS_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

FILE: design/kls_pkg.sv
// ----------------------------------------------------------------------------
// kls_pkg
// shared constants and types of the k-th largest stream tracker
// ----------------------------------------------------------------------------
package kls_pkg;

	localparam int MAX_RANK = 256;
	localparam int ADDR_W   = $clog2(MAX_RANK);
	localparam int RANK_W   = 9;
	localparam int NODE_W   = ADDR_W + 2;
	localparam int DATA_W   = 32;

	localparam logic signed [DATA_W-1:0] MOST_NEG = {1'b1, {(DATA_W-1){1'b0}}};

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_CLEAR  = 1'b1
	} op_t;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_RD_L = 5'b00010,
		ST_RD_R = 5'b00100,
		ST_CMP  = 5'b01000,
		ST_FIN  = 5'b10000
	} state_t;

endpackage

FILE: design/kls_ram.sv
// ----------------------------------------------------------------------------
// kls_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module kls_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

FILE: design/kth_largest_stream_tracker.sv
// ----------------------------------------------------------------------------
// kth_largest_stream_tracker
// min-heap of the k largest signed values seen; reports the heap root
// ----------------------------------------------------------------------------
//  channel   signals                          direction  transfer
//  item      item_valid/item_ready,            in         valid && ready
//            operation, value
//  result    result_valid/result_ready,        out        valid && ready
//            kth_value
//  config    cfg_wr_en, cfg_wr_data            in         cfg_wr_en
//
//  clear and non-replacing inserts: result in the cycle after the transfer.
//  replacing insert: walks the heap level by level (read left, read right,
//  compare and write on the single heap ram), then a finish step.
//  reset and clear drop per-entry valid bits at once; no clearing pass.
//  a pending result blocks the next item only until it is taken.
// ----------------------------------------------------------------------------
`include "kth_largest_stream_tracker_defines.svh"

module kth_largest_stream_tracker
	import kls_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_wr_en,
	input  logic [RANK_W-1:0]        cfg_wr_data,
	input  logic                     item_valid,
	output logic                     item_ready,
	input  logic                     operation,
	input  logic signed [DATA_W-1:0] value,
	output logic                     result_valid,
	input  logic                     result_ready,
	output logic signed [DATA_W-1:0] kth_value
);

	state_t                   state_q;
	logic [RANK_W-1:0]        rank_q;
	logic [RANK_W-1:0]        n_act;
	logic [RANK_W-1:0]        n_q;
	logic [ADDR_W-1:0]        pos_q;
	logic signed [DATA_W-1:0] cur_val_q;
	logic signed [DATA_W-1:0] root_q;
	logic signed [DATA_W-1:0] left_val_q;
	logic [MAX_RANK-1:0]      valid_q;
	logic                     rd_ok_q;
	logic                     result_valid_q;
	logic signed [DATA_W-1:0] kth_q;

	logic                     item_xfer;
	logic [NODE_W-1:0]        left_idx;
	logic [NODE_W-1:0]        right_idx;
	logic                     has_left;
	logic                     has_right;
	logic                     pick_right;
	logic signed [DATA_W-1:0] child_val;
	logic [ADDR_W-1:0]        pick_addr;

	logic                     wr_en;
	logic [ADDR_W-1:0]        wr_addr;
	logic signed [DATA_W-1:0] wr_data;
	logic [ADDR_W-1:0]        rd_addr;
	logic [DATA_W-1:0]        ram_rd_data;
	logic signed [DATA_W-1:0] rd_val;

	kls_ram #(
		.WIDTH(DATA_W),
		.DEPTH(MAX_RANK)
	) u_heap_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(rd_addr),
		.rd_data(ram_rd_data)
	);

	// entries never written since the last clear read as the most negative value
	assign rd_val = rd_ok_q ? $signed(ram_rd_data) : MOST_NEG;

	always_comb begin
		if (rank_q == '0) begin
			n_act = RANK_W'(1);
		end else if (rank_q > RANK_W'(MAX_RANK)) begin
			n_act = RANK_W'(MAX_RANK);
		end else begin
			n_act = rank_q;
		end
	end

	assign item_ready = (state_q == ST_IDLE) && (!result_valid_q || result_ready);
	assign item_xfer  = item_valid && item_ready;

	assign left_idx   = {1'b0, pos_q, 1'b1};
	assign right_idx  = left_idx + NODE_W'(1);
	assign has_left   = left_idx < NODE_W'(n_q);
	assign has_right  = right_idx < NODE_W'(n_q);
	assign pick_right = has_right && (rd_val < left_val_q);
	assign child_val  = pick_right ? rd_val : left_val_q;
	assign pick_addr  = pick_right ? right_idx[ADDR_W-1:0] : left_idx[ADDR_W-1:0];

	// hole-style sift: the new value stays in cur_val_q until its slot is found
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = pos_q;
		wr_data = cur_val_q;
		rd_addr = left_idx[ADDR_W-1:0];
		case (state_q)
			ST_RD_L: begin
				if (!has_left) begin
					wr_en = 1'b1;
				end
			end
			ST_RD_R: begin
				rd_addr = right_idx[ADDR_W-1:0];
			end
			ST_CMP: begin
				wr_en = 1'b1;
				if (child_val < cur_val_q) begin
					wr_data = child_val;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			rank_q         <= RANK_W'(1);
			valid_q        <= '0;
			root_q         <= MOST_NEG;
			result_valid_q <= 1'b0;
			rd_ok_q        <= 1'b0;
			pos_q          <= '0;
			n_q            <= RANK_W'(1);
			cur_val_q      <= MOST_NEG;
			left_val_q     <= MOST_NEG;
			kth_q          <= MOST_NEG;
		end else begin
			rd_ok_q <= valid_q[rd_addr];
			if (result_valid_q && result_ready) begin
				result_valid_q <= 1'b0;
			end
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
				if (wr_addr == '0) begin
					root_q <= wr_data;
				end
			end
			case (state_q)
				ST_IDLE: begin
					if (item_xfer) begin
						if (operation == OP_CLEAR) begin
							valid_q        <= '0;
							root_q         <= MOST_NEG;
							kth_q          <= MOST_NEG;
							result_valid_q <= 1'b1;
						end else if (value > root_q) begin
							cur_val_q <= value;
							n_q       <= n_act;
							state_q   <= ST_RD_L;
						end else begin
							kth_q          <= root_q;
							result_valid_q <= 1'b1;
						end
					end
				end
				ST_RD_L: begin
					state_q <= has_left ? ST_RD_R : ST_FIN;
				end
				ST_RD_R: begin
					left_val_q <= rd_val;
					state_q    <= ST_CMP;
				end
				ST_CMP: begin
					if (child_val < cur_val_q) begin
						pos_q   <= pick_addr;
						state_q <= ST_RD_L;
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					kth_q          <= root_q;
					result_valid_q <= 1'b1;
					pos_q          <= '0;
					state_q        <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			// rank rewrite empties the heap like a clear
			if (cfg_wr_en) begin
				rank_q  <= cfg_wr_data;
				valid_q <= '0;
				root_q  <= MOST_NEG;
			end
		end
	end

	assign result_valid = result_valid_q;
	assign kth_value    = kth_q;

	`KLS_ASSERT_NEXT(a_clear_result, item_xfer && (operation == OP_CLEAR),
		result_valid && (kth_value == MOST_NEG), "clear did not report most negative value")
	`KLS_ASSERT_SAME(a_pos_in_heap, state_q != ST_IDLE,
		RANK_W'(pos_q) < n_q, "sift position outside active heap")
	`KLS_ASSERT_SAME(a_write_in_heap, wr_en,
		RANK_W'(wr_addr) < n_q, "heap write outside active heap")
	`KLS_ASSERT_SAME(a_busy_no_accept, state_q != ST_IDLE,
		!item_ready && !result_valid_q, "item taken or result shown during sift")

endmodule

FILE: tb/tb_kth_largest_stream_tracker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_kth_largest_stream_tracker
// drives insert and clear items through the k-th largest tracker at several
// ranks, keeps its own min-heap of the kept values and checks every reported
// root in order; sender bursts and receiver stalls are randomized
// ----------------------------------------------------------------------------
module tb_kth_largest_stream_tracker;
	import kls_pkg::*;

	localparam logic signed [DATA_W-1:0] MOST_POS = {1'b0, {(DATA_W-1){1'b1}}};
	localparam int SIFT_SETTLE = 40;
	localparam int N_PHASES    = 12;
	localparam int N_DIRECTED  = 22;

	typedef enum int {
		SINK_OPEN,
		SINK_COIN,
		SINK_SLOW,
		SINK_HICCUP
	} sink_mode_t;

	typedef struct {
		logic                     is_cfg;
		logic [RANK_W-1:0]        rank;
		op_t                      op;
		logic signed [DATA_W-1:0] val;
		logic                     has_typed;
		logic signed [DATA_W-1:0] kth_typed;
	} dir_row_t;

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     cfg_wr_en;
	logic [RANK_W-1:0]        cfg_wr_data;
	logic                     item_valid;
	logic                     item_ready;
	logic                     operation;
	logic signed [DATA_W-1:0] value;
	logic                     result_valid;
	logic                     result_ready;
	logic signed [DATA_W-1:0] kth_value;

	// own copy of the tracker state
	logic signed [DATA_W-1:0] heap_model [MAX_RANK];
	logic [RANK_W-1:0]        rank_reg;

	logic signed [DATA_W-1:0] kth_expect_q [$];
	int unsigned              fail_count = 0;
	int unsigned              burst_left = 0;

	kth_largest_stream_tracker u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.operation    (operation),
		.value        (value),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.kth_value    (kth_value)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic void refill_heap();
		for (int i = 0; i < MAX_RANK; i++)
			heap_model[i] = MOST_NEG;
	endfunction

	function automatic int unsigned heap_size();
		if (rank_reg == 0)
			return 1;
		if (rank_reg > MAX_RANK)
			return MAX_RANK;
		return rank_reg;
	endfunction

	function automatic void sift_root(int unsigned n);
		int unsigned              pos;
		int unsigned              left;
		int unsigned              right;
		int unsigned              pick;
		logic signed [DATA_W-1:0] tmp;
		logic                     done;
		pos  = 0;
		done = 1'b0;
		while (!done) begin
			left  = 2 * pos + 1;
			right = left + 1;
			if (left >= n) begin
				done = 1'b1;
			end else begin
				pick = left;
				if (right < n && heap_model[right] < heap_model[left])
					pick = right;
				if (heap_model[pick] >= heap_model[pos]) begin
					done = 1'b1;
				end else begin
					tmp              = heap_model[pos];
					heap_model[pos]  = heap_model[pick];
					heap_model[pick] = tmp;
					pos              = pick;
				end
			end
		end
	endfunction

	function automatic logic signed [DATA_W-1:0] kth_after_item(op_t op,
			logic signed [DATA_W-1:0] v);
		if (op == OP_CLEAR) begin
			refill_heap();
		end else if (v > heap_model[0]) begin
			heap_model[0] = v;
			sift_root(heap_size());
		end
		return heap_model[0];
	endfunction

	// append one expected root at the tail of the scoreboard
	function automatic void queue_expect(logic signed [DATA_W-1:0] kth);
		kth_expect_q = {kth_expect_q, kth};
	endfunction

	function automatic logic signed [DATA_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 3))
					0: return MOST_NEG;
					1: return MOST_POS;
					2: return -1;
					default: return 0;
				endcase
			end
			// narrow range so equal values and ties show up
			1, 2, 3: return $signed($urandom_range(0, 40)) - 20;
			default: return $signed($urandom());
		endcase
	endfunction

	// one transfer on the item channel, then the predictor's root after it
	task automatic send_item(input op_t op, input logic signed [DATA_W-1:0] v,
			output logic signed [DATA_W-1:0] kth_next);
		int unsigned gap;
		@(negedge clk);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				item_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		item_valid <= 1'b1;
		operation  <= op;
		value      <= v;
		do
			@(posedge clk);
		while (!item_ready);
		burst_left--;
		kth_next = kth_after_item(op, v);
	endtask

	task automatic go_idle();
		@(negedge clk);
		item_valid <= 1'b0;
		burst_left = 0;
	endtask

	// rank writes only once every result is back and the sift has settled
	task automatic write_rank(input logic [RANK_W-1:0] r);
		while (kth_expect_q.size() != 0)
			@(posedge clk);
		repeat (SIFT_SETTLE) @(posedge clk);
		@(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= r;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		rank_reg = r;
		refill_heap();
	endtask

	initial begin : result_sink
		sink_mode_t mode;
		int         hold;
		result_ready = 1'b0;
		forever begin
			mode = sink_mode_t'($urandom_range(0, 3));
			hold = $urandom_range(16, 80);
			repeat (hold) begin
				@(negedge clk);
				case (mode)
					SINK_OPEN:   result_ready <= 1'b1;
					SINK_COIN:   result_ready <= 1'($urandom_range(0, 1));
					SINK_SLOW:   result_ready <= ($urandom_range(0, 3) == 0);
					SINK_HICCUP: result_ready <= ($urandom_range(0, 7) != 0);
					default:     result_ready <= 1'b1;
				endcase
			end
		end
	end

	always @(posedge clk) begin : result_check
		logic signed [DATA_W-1:0] kth_exp;
		if (arst_n && result_valid && result_ready) begin
			if (kth_expect_q.size() == 0) begin
				$display("%0t: unexpected result transfer, expected none, actual %0d",
					$time, kth_value);
				fail_count++;
			end else begin
				kth_exp = kth_expect_q.pop_front();
				if (kth_value !== kth_exp) begin
					$display("%0t: kth_value mismatch, expected %0d, actual %0d",
						$time, kth_exp, kth_value);
					fail_count++;
				end
			end
		end
	end

	initial begin : stimulus
		dir_row_t dir_rows [N_DIRECTED];
		int unsigned phase_rank  [N_PHASES];
		int unsigned phase_items [N_PHASES];
		logic signed [DATA_W-1:0] kth_next;
		logic signed [DATA_W-1:0] v;
		op_t         op;
		int unsigned clear_pct;
		int unsigned drain;
		logic        missing_results;

		dir_rows = '{
			'{1'b0, 9'd0,   OP_INSERT, MOST_NEG,   1'b1, MOST_NEG},
			'{1'b0, 9'd0,   OP_INSERT, MOST_POS,   1'b1, MOST_POS},
			'{1'b0, 9'd0,   OP_INSERT, MOST_POS,   1'b1, MOST_POS},
			'{1'b0, 9'd0,   OP_INSERT, -1,         1'b1, MOST_POS},
			'{1'b0, 9'd0,   OP_CLEAR,  MOST_POS,   1'b1, MOST_NEG},
			'{1'b0, 9'd0,   OP_INSERT, -5,         1'b1, -5},
			'{1'b0, 9'd0,   OP_INSERT, 3,          1'b1, 3},
			'{1'b1, 9'd3,   OP_INSERT, 0,          1'b0, 0},
			'{1'b0, 9'd0,   OP_INSERT, 10,         1'b1, MOST_NEG},
			'{1'b0, 9'd0,   OP_INSERT, 20,         1'b1, MOST_NEG},
			'{1'b0, 9'd0,   OP_INSERT, 5,          1'b1, 5},
			'{1'b0, 9'd0,   OP_INSERT, 30,         1'b1, 10},
			'{1'b0, 9'd0,   OP_INSERT, 7,          1'b0, 0},
			'{1'b0, 9'd0,   OP_INSERT, MOST_POS,   1'b0, 0},
			'{1'b1, 9'd0,   OP_INSERT, 0,          1'b0, 0},
			'{1'b0, 9'd0,   OP_INSERT, -7,         1'b1, -7},
			'{1'b0, 9'd0,   OP_INSERT, MOST_NEG,   1'b0, 0},
			'{1'b1, 9'd511, OP_INSERT, 0,          1'b0, 0},
			'{1'b0, 9'd0,   OP_INSERT, 100,        1'b1, MOST_NEG},
			'{1'b0, 9'd0,   OP_CLEAR,  -1,         1'b1, MOST_NEG},
			'{1'b1, 9'd256, OP_INSERT, 0,          1'b0, 0},
			'{1'b0, 9'd0,   OP_INSERT, 1,          1'b1, MOST_NEG}
		};
		phase_rank  = '{2, 5, 1, 16, 256, 3, 0, 64, 300, 9, 511, 31};
		phase_items = '{60, 60, 40, 70, 290, 50, 40, 90, 60, 60, 30, 60};
		phase_rank[N_PHASES-1] = $urandom_range(17, 48);

		arst_n          = 1'b0;
		item_valid      = 1'b0;
		operation       = OP_INSERT;
		value           = '0;
		cfg_wr_en       = 1'b0;
		cfg_wr_data     = '0;
		rank_reg        = 1;
		missing_results = 1'b0;
		refill_heap();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i]) begin
			if (dir_rows[i].is_cfg) begin
				go_idle();
				write_rank(dir_rows[i].rank);
			end else begin
				send_item(dir_rows[i].op, dir_rows[i].val, kth_next);
				queue_expect(dir_rows[i].has_typed ? dir_rows[i].kth_typed : kth_next);
			end
		end

		for (int p = 0; p < N_PHASES; p++) begin
			go_idle();
			write_rank(RANK_W'(phase_rank[p]));
			// no clears at full depth so the heap gets past its filling stage
			clear_pct = (heap_size() >= MAX_RANK) ? 0 : 3;
			repeat (phase_items[p]) begin
				op = ($urandom_range(0, 99) < clear_pct) ? OP_CLEAR : OP_INSERT;
				v  = pick_value();
				send_item(op, v, kth_next);
				queue_expect(kth_next);
			end
		end

		go_idle();
		drain = 0;
		while (kth_expect_q.size() != 0 && drain < 20000) begin
			@(posedge clk);
			drain++;
		end
		if (kth_expect_q.size() != 0) begin
			$display("%0t: results missing, expected %0d more, actual 0",
				$time, kth_expect_q.size());
			missing_results = 1'b1;
		end
		repeat (SIFT_SETTLE) @(posedge clk);

		if (fail_count == 0 && !missing_results)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin : watchdog
		#(2_000_000);
		$display("Regression FAIL");
		$finish;
	end

endmodule

FILE: files.f
+incdir+design
design/kls_pkg.sv
design/kls_ram.sv
design/kth_largest_stream_tracker.sv
tb/tb_kth_largest_stream_tracker.sv
